// ----- rtl/rsi_pkg.sv -----
// Shared types and constants of the ray/sphere intersection pipeline.
package rsi_pkg;

    // Operand slice width of the pipelined multipliers.
    localparam int MUL_CHUNK = 32;

    // Latency of rsi_mul in cycles.
    localparam int MUL_LAT = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_RADIUS   = 2'd3;

    // Pipeline control handed to every stage block.
    typedef struct packed {
        logic en;   // whole pipe advances
        logic vld;  // word entering the block is valid
    } t_pipe_ctl;

endpackage

// ----- rtl/rsi_mul.sv -----
// Pipelined signed multiplier built from 32x32 partial products.
module rsi_mul #(
    parameter int XW  = 32,
    parameter int YW  = 32,
    parameter int TGW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rsi_pkg::t_pipe_ctl       i_ctl,
    input  logic signed [XW-1:0]     i_x,
    input  logic signed [YW-1:0]     i_y,
    input  logic [TGW-1:0]           i_tag,
    output logic signed [XW+YW-1:0]  o_p,
    output logic [TGW-1:0]           o_tag,
    output logic                     o_vld
);

    localparam int CH = rsi_pkg::MUL_CHUNK;
    localparam int NX = (XW + CH - 1) / CH;
    localparam int NY = (YW + CH - 1) / CH;
    localparam int XP = NX * CH;
    localparam int YP = NY * CH;
    localparam int PW = XW + YW;
    localparam int LAT = rsi_pkg::MUL_LAT;

    logic [XW-1:0]   xa;
    logic [YW-1:0]   ya;
    logic [XP-1:0]   r_xm;
    logic [YP-1:0]   r_ym;
    logic [2*CH-1:0] r_pp [NX][NY];
    logic [PW-1:0]   n_row [NX];
    logic [PW-1:0]   r_row [NX];
    logic [PW-1:0]   n_sum;
    logic [PW-1:0]   r_sum;
    logic [PW-1:0]   r_p;
    logic [LAT-2:0]  r_sg;
    logic [TGW-1:0]  r_tag [LAT];
    logic [LAT-1:0]  r_vld;

    assign xa = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
    assign ya = i_y[YW-1] ? YW'(-i_y) : YW'(i_y);

    always_comb begin
        for (int i = 0; i < NX; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NY; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * CH));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NX; i++) begin
            n_sum = n_sum + (r_row[i] << (i * CH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_xm <= XP'(xa);
            r_ym <= YP'(ya);
            for (int i = 0; i < NX; i++) begin
                for (int j = 0; j < NY; j++) begin
                    r_pp[i][j] <= (2*CH)'(r_xm[i*CH +: CH]) * (2*CH)'(r_ym[j*CH +: CH]);
                end
            end
            r_row <= n_row;
            r_sum <= n_sum;
            r_p   <= r_sg[LAT-2] ? PW'(-r_sum) : r_sum;
            r_sg  <= {r_sg[LAT-3:0], i_x[XW-1] ^ i_y[YW-1]};
            r_tag[0] <= i_tag;
            for (int k = 1; k < LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[LAT-2:0], i_ctl.vld};
        end
    end

    assign o_p   = $signed(r_p);
    assign o_tag = r_tag[LAT-1];
    assign o_vld = r_vld[LAT-1];

endmodule

// ----- rtl/rsi_sqrt.sv -----
// Pipelined floor square root, one root bit per stage.
module rsi_sqrt #(
    parameter int DW  = 134,
    parameter int TGW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsi_pkg::t_pipe_ctl    i_ctl,
    input  logic [DW-1:0]         i_rad,
    input  logic [TGW-1:0]        i_tag,
    output logic [DW/2-1:0]       o_root,
    output logic [TGW-1:0]        o_tag,
    output logic                  o_vld
);

    localparam int RW = DW / 2;
    localparam int TW = DW + 1;

    logic [DW-1:0]  w_rem  [RW];
    logic [RW-1:0]  w_root [RW];
    logic [TGW-1:0] w_tag  [RW];
    logic           w_vld  [RW];
    logic [DW-1:0]  r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [TGW-1:0] r_tag  [RW];
    logic           r_vld  [RW];

    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_tag[0]  = i_tag;
    assign w_vld[0]  = i_ctl.vld;

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int BIT = RW - 1 - s;
        logic [TW-1:0] trial;
        logic          ge;

        if (s > 0) begin : g_link
            assign w_rem[s]  = r_rem[s-1];
            assign w_root[s] = r_root[s-1];
            assign w_tag[s]  = r_tag[s-1];
            assign w_vld[s]  = r_vld[s-1];
        end

        assign trial = (TW'(w_root[s]) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        assign ge    = ({1'b0, w_rem[s]} >= trial);

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[s]  <= ge ? w_rem[s] - trial[DW-1:0] : w_rem[s];
                r_root[s] <= ge ? (w_root[s] | (RW'(1) << BIT)) : w_root[s];
                r_tag[s]  <= w_tag[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= w_vld[s];
            end
        end
    end

    assign o_root = r_root[RW-1];
    assign o_tag  = r_tag[RW-1];
    assign o_vld  = r_vld[RW-1];

endmodule

// ----- rtl/rsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rsi_div #(
    parameter int NUW = 85,
    parameter int DVW = 64,
    parameter int QW  = 32,
    parameter int TGW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rsi_pkg::t_pipe_ctl    i_ctl,
    input  logic [NUW-1:0]        i_num,
    input  logic [DVW-1:0]        i_dvs,
    input  logic [TGW-1:0]        i_tag,
    output logic [QW-1:0]         o_quo,
    output logic                  o_ovf,
    output logic [TGW-1:0]        o_tag,
    output logic                  o_vld
);

    localparam int CMW = (NUW > DVW + QW) ? NUW : DVW + QW;

    logic [DVW-1:0] r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [DVW-1:0] r_dvs [QW+1];
    logic [QW-1:0]  r_quo [QW+1];
    logic           r_ovf [QW+1];
    logic [TGW-1:0] r_tag [QW+1];
    logic           r_vld [QW+1];

    // quotient of 2^QW or more sets the overflow flag; only the low QW bits are developed
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ovf[0] <= (CMW'(i_num) >= (CMW'(i_dvs) << QW));
            r_rem[0] <= DVW'(i_num >> QW);
            r_low[0] <= i_num[QW-1:0];
            r_dvs[0] <= i_dvs;
            r_quo[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        localparam int BIT = QW - s;
        logic [DVW:0] part;
        logic         ge;

        assign part = {r_rem[s-1], r_low[s-1][BIT]};
        assign ge   = (part >= {1'b0, r_dvs[s-1]});

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[s] <= ge ? DVW'(part - {1'b0, r_dvs[s-1]}) : DVW'(part);
                r_low[s] <= r_low[s-1];
                r_dvs[s] <= r_dvs[s-1];
                r_quo[s] <= {r_quo[s-1][QW-2:0], ge};
                r_ovf[s] <= r_ovf[s-1];
                r_tag[s] <= r_tag[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];
    assign o_tag = r_tag[QW];
    assign o_vld = r_vld[QW];

endmodule

// ----- rtl/ray_sphere_intersect.sv -----
// Top level of the ray/sphere intersection pipeline: registers, coefficients, output buffer.
//
//  channel  | handshake             | word
//  ---------+-----------------------+------------------------------------------
//  ray in   | i_valid / o_stall     | i_origin_{x,y,z}, i_heading_{x,y,z}
//  hit out  | o_valid / i_stall     | o_hit, o_distance, o_saturated
//  config   | APB psel/penable/...  | center_{x,y,z} at 0,4,8; radius at 12
//
//  One ray accepted per cycle while o_stall is low. The path runs through the
//  one-bit-per-stage square root (2*COORD_WIDTH+3) and divider
//  (COORD_WIDTH+1) plus two 5-stage multiplier banks.
//  Synchronous active-low reset clears valid bits and the sphere registers.
//  A stalled output word sits in the output register; one more word fits in a
//  skid register, and o_stall rises only when that skid register is full.
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PAW = (COORD_WIDTH > 32) ? 5 : 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PAW-1:0]                paddr,
    input  logic [PDW-1:0]                pwdata,
    output logic [PDW-1:0]                prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_heading_x,
    input  logic signed [COORD_WIDTH-1:0] i_heading_y,
    input  logic signed [COORD_WIDTH-1:0] i_heading_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_distance,
    output logic                          o_saturated
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int VW  = W + 1;
    localparam int AW  = 2 * W + 1;
    localparam int BW  = 2 * W + 3;
    localparam int CW  = 2 * W + 4;
    localparam int DW  = 2 * BW;
    localparam int RW  = DW / 2;
    localparam int NW  = RW + 2;
    localparam int NUW = NW + F;
    localparam int DVW = 2 * W;
    localparam int OW  = W + 2;

    localparam logic signed [W-1:0] DIST_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DIST_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] DIST_MISS = -(W'(1) << F);
    localparam logic [W-1:0]        NEG_LIMIT = W'(1) << (W - 1);

    // ---------------- configuration
    logic signed [W-1:0] r_cx, r_cy, r_cz;
    logic [W-2:0]        r_rad;
    logic [1:0]          cfg_idx;

    assign cfg_idx = paddr[PAW-1:PAW-2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                rsi_pkg::REG_CENTER_X: r_cx  <= pwdata[W-1:0];
                rsi_pkg::REG_CENTER_Y: r_cy  <= pwdata[W-1:0];
                rsi_pkg::REG_CENTER_Z: r_cz  <= pwdata[W-1:0];
                rsi_pkg::REG_RADIUS:   r_rad <= pwdata[W-2:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rsi_pkg::REG_CENTER_X: prdata = PDW'($unsigned(r_cx));
            rsi_pkg::REG_CENTER_Y: prdata = PDW'($unsigned(r_cy));
            rsi_pkg::REG_CENTER_Z: prdata = PDW'($unsigned(r_cz));
            rsi_pkg::REG_RADIUS:   prdata = PDW'(r_rad);
        endcase
    end

    // ---------------- pipe control
    logic en;
    logic r_ov, r_sv;

    assign en      = !r_sv;
    assign o_stall = r_sv;

    // ---------------- stage 1: heading, offset from center
    logic signed [W-1:0]  r1_d [3];
    logic signed [VW-1:0] r1_v [3];
    logic signed [W-1:0]  r1_r;
    logic                 r1_vld;
    rsi_pkg::t_pipe_ctl   ctl1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= i_heading_x;
            r1_d[1] <= i_heading_y;
            r1_d[2] <= i_heading_z;
            r1_v[0] <= VW'(i_origin_x) - VW'(r_cx);
            r1_v[1] <= VW'(i_origin_y) - VW'(r_cy);
            r1_v[2] <= VW'(i_origin_z) - VW'(r_cz);
            r1_r    <= $signed({1'b0, r_rad});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    assign ctl1 = '{en: en, vld: r1_vld};

    logic signed [2*W-1:0]  m_dd [3];
    logic signed [W+VW-1:0] m_dv [3];
    logic signed [2*VW-1:0] m_vv [3];
    logic signed [2*W-1:0]  m_rr;
    logic                   m1_vld;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        rsi_mul #(.XW(W), .YW(W), .TGW(1)) u_dd (
            .i_clk, .i_rst_n, .i_ctl(ctl1), .i_x(r1_d[k]), .i_y(r1_d[k]),
            .i_tag(1'b0), .o_p(m_dd[k]), .o_tag(), .o_vld()
        );
        rsi_mul #(.XW(W), .YW(VW), .TGW(1)) u_dv (
            .i_clk, .i_rst_n, .i_ctl(ctl1), .i_x(r1_d[k]), .i_y(r1_v[k]),
            .i_tag(1'b0), .o_p(m_dv[k]), .o_tag(), .o_vld()
        );
        rsi_mul #(.XW(VW), .YW(VW), .TGW(1)) u_vv (
            .i_clk, .i_rst_n, .i_ctl(ctl1), .i_x(r1_v[k]), .i_y(r1_v[k]),
            .i_tag(1'b0), .o_p(m_vv[k]), .o_tag(), .o_vld()
        );
    end

    rsi_mul #(.XW(W), .YW(W), .TGW(1)) u_rr (
        .i_clk, .i_rst_n, .i_ctl(ctl1), .i_x(r1_r), .i_y(r1_r),
        .i_tag(1'b0), .o_p(m_rr), .o_tag(), .o_vld(m1_vld)
    );

    // ---------------- stage 2: A, B, C
    logic signed [AW-1:0] r2_a;
    logic signed [BW-1:0] r2_b;
    logic signed [CW-1:0] r2_c;
    logic                 r2_vld;
    rsi_pkg::t_pipe_ctl   ctl2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a <= AW'(m_dd[0]) + AW'(m_dd[1]) + AW'(m_dd[2]);
            r2_b <= BW'(m_dv[0]) + BW'(m_dv[1]) + BW'(m_dv[2]);
            r2_c <= CW'(m_vv[0]) + CW'(m_vv[1]) + CW'(m_vv[2]) - CW'(m_rr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= m1_vld;
        end
    end

    assign ctl2 = '{en: en, vld: r2_vld};

    logic signed [2*BW-1:0]  m_bb;
    logic signed [AW+CW-1:0] m_ac;
    logic [AW+BW-1:0]        m2_tag;
    logic                    m2_vld;

    rsi_mul #(.XW(BW), .YW(BW), .TGW(AW+BW)) u_bb (
        .i_clk, .i_rst_n, .i_ctl(ctl2), .i_x(r2_b), .i_y(r2_b),
        .i_tag({r2_a, r2_b}), .o_p(m_bb), .o_tag(m2_tag), .o_vld(m2_vld)
    );
    rsi_mul #(.XW(AW), .YW(CW), .TGW(1)) u_ac (
        .i_clk, .i_rst_n, .i_ctl(ctl2), .i_x(r2_a), .i_y(r2_c),
        .i_tag(1'b0), .o_p(m_ac), .o_tag(), .o_vld()
    );

    // ---------------- stage 3: discriminant, miss test
    logic signed [DW-1:0] disc;
    logic [AW-1:0]        m2_a;
    logic                 miss3;
    logic [DW-1:0]        r3_rad;
    logic [AW+BW:0]       r3_tag;
    logic                 r3_vld;
    rsi_pkg::t_pipe_ctl   ctl3;

    assign disc  = DW'(m_bb) - DW'(m_ac);
    assign m2_a  = m2_tag[AW+BW-1:BW];
    assign miss3 = (m2_a == '0) || disc[DW-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rad <= disc[DW-1] ? '0 : $unsigned(disc);
            r3_tag <= {miss3, m2_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= m2_vld;
        end
    end

    assign ctl3 = '{en: en, vld: r3_vld};

    logic [RW-1:0]  sq_root;
    logic [AW+BW:0] sq_tag;
    logic           sq_vld;

    rsi_sqrt #(.DW(DW), .TGW(AW+BW+1)) u_sqrt (
        .i_clk, .i_rst_n, .i_ctl(ctl3), .i_rad(r3_rad), .i_tag(r3_tag),
        .o_root(sq_root), .o_tag(sq_tag), .o_vld(sq_vld)
    );

    // ---------------- stage 4: both root numerators
    logic signed [NW-1:0] sq_b;
    logic signed [NW-1:0] sq_s;
    logic signed [NW-1:0] r4_n1, r4_n2;
    logic                 r4_miss;
    logic [AW-1:0]        r4_a;
    logic                 r4_vld;

    assign sq_b = NW'($signed(sq_tag[BW-1:0]));
    assign sq_s = $signed(NW'(sq_root));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_n1   <= -sq_b - sq_s;
            r4_n2   <= -sq_b + sq_s;
            r4_miss <= sq_tag[AW+BW];
            r4_a    <= sq_tag[AW+BW-1:BW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= sq_vld;
        end
    end

    // ---------------- stage 5: pick near root when positive, take magnitude
    logic signed [NW-1:0] pick;
    logic [NW-1:0]        pick_mag;
    logic [NUW-1:0]       r5_num;
    logic [DVW-1:0]       r5_dvs;
    logic [1:0]           r5_tag;
    logic                 r5_vld;
    rsi_pkg::t_pipe_ctl   ctl5;

    assign pick     = (r4_n1[NW-1] || (r4_n1 == '0)) ? r4_n2 : r4_n1;
    assign pick_mag = pick[NW-1] ? NW'(-pick) : NW'(pick);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_num <= {pick_mag, {F{1'b0}}};
            r5_dvs <= r4_a[DVW-1:0];
            r5_tag <= {r4_miss, pick[NW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    assign ctl5 = '{en: en, vld: r5_vld};

    logic [W-1:0] dv_quo;
    logic         dv_ovf;
    logic [1:0]   dv_tag;
    logic         dv_vld;

    rsi_div #(.NUW(NUW), .DVW(DVW), .QW(W), .TGW(2)) u_div (
        .i_clk, .i_rst_n, .i_ctl(ctl5), .i_num(r5_num), .i_dvs(r5_dvs), .i_tag(r5_tag),
        .o_quo(dv_quo), .o_ovf(dv_ovf), .o_tag(dv_tag), .o_vld(dv_vld)
    );

    // ---------------- sign, saturation, miss word
    logic         f_sat;
    logic [W-1:0] f_dist;
    logic [OW-1:0] p_word;

    always_comb begin
        priority if (dv_tag[1]) begin
            f_sat  = 1'b0;
            f_dist = DIST_MISS;
        end else if (!dv_tag[0]) begin
            f_sat  = dv_ovf || dv_quo[W-1];
            f_dist = f_sat ? DIST_MAX : dv_quo;
        end else begin
            f_sat  = dv_ovf || (dv_quo > NEG_LIMIT);
            f_dist = f_sat ? DIST_MIN : W'(-dv_quo);
        end
    end

    assign p_word = {!dv_tag[1], f_dist, f_sat};

    // ---------------- output register and skid
    logic [OW-1:0] r_od, r_sd;
    logic          out_take;

    assign out_take = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (en) begin
            if (!r_ov || out_take) begin
                r_ov <= dv_vld;
            end else if (dv_vld) begin
                r_sv <= 1'b1;
            end
        end else if (out_take) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_ov || out_take) begin
                r_od <= p_word;
            end else begin
                r_sd <= p_word;
            end
        end else if (out_take) begin
            r_od <= r_sd;
        end
    end

    assign o_valid     = r_ov;
    assign o_hit       = r_od[OW-1];
    assign o_distance  = $signed(r_od[OW-2:1]);
    assign o_saturated = r_od[0];

    // ---------------- checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid word held with empty output register");

    a_miss_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_distance == DIST_MISS && !o_saturated))
        else $error("miss word malformed");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_hit && (o_distance == DIST_MAX ||
                                                o_distance == DIST_MIN)))
        else $error("saturated distance not at a limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall && !r_sv && dv_vld) |=> r_sv)
        else $error("word arriving under stall not kept in skid");

endmodule

// ----- verif/rsi_checker.sv -----
// Checker for ray_sphere_intersect: tracks registers, predicts each hit word, compares.
`timescale 1ns / 1ps

module rsi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_origin_x,
    input  logic [31:0] i_origin_y,
    input  logic [31:0] i_origin_z,
    input  logic [31:0] i_heading_x,
    input  logic [31:0] i_heading_y,
    input  logic [31:0] i_heading_z,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_hit,
    input  logic [31:0] o_distance,
    input  logic        o_saturated,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic        saturated;
    } t_hit_word;

    logic [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0] radius;
    t_hit_word   hit_q[$];

    function automatic t_hit_word trace_ray(
        logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
        logic signed [31:0] hx, logic signed [31:0] hy, logic signed [31:0] hz,
        logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz,
        logic [30:0] rad);
        logic signed [255:0] dx, dy, dz, vx, vy, vz, rr, a, b, c, disc, num, q;
        logic [255:0] root, cand;
        logic neg;
        t_hit_word res;
        int k;
        dx = hx;
        dy = hy;
        dz = hz;
        vx = ox;
        vy = oy;
        vz = oz;
        vx = vx - cx;
        vy = vy - cy;
        vz = vz - cz;
        rr = {225'b0, rad};
        a = dx * dx + dy * dy + dz * dz;
        b = dx * vx + dy * vy + dz * vz;
        c = vx * vx + vy * vy + vz * vz - rr * rr;
        disc = b * b - a * c;
        if (a == 0 || disc < 0) begin
            res.hit = 1'b0;
            res.distance = 32'hFFFF_0000;
            res.saturated = 1'b0;
            return res;
        end
        root = '0;
        for (k = 127; k >= 0; k--) begin
            cand = root | (256'd1 << k);
            if (cand * cand <= disc) root = cand;
        end
        num = -b - $signed(root);
        if (num <= 0) num = -b + $signed(root);
        neg = num < 0;
        if (neg) num = -num;
        q = (num <<< 16) / a;
        if (neg) q = -q;
        res.hit = 1'b1;
        res.saturated = 1'b0;
        if (q > 256'sh7FFF_FFFF) begin
            q = 256'sh7FFF_FFFF;
            res.saturated = 1'b1;
        end else if (q < -256'sh8000_0000) begin
            q = -256'sh8000_0000;
            res.saturated = 1'b1;
        end
        res.distance = q[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hit_word exp_w;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            ctr_x <= '0;
            ctr_y <= '0;
            ctr_z <= '0;
            radius <= '0;
            hit_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    rsi_pkg::REG_CENTER_X: ctr_x <= pwdata;
                    rsi_pkg::REG_CENTER_Y: ctr_y <= pwdata;
                    rsi_pkg::REG_CENTER_Z: ctr_z <= pwdata;
                    rsi_pkg::REG_RADIUS:   radius <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                hit_q.push_back(trace_ray(i_origin_x, i_origin_y, i_origin_z,
                                          i_heading_x, i_heading_y, i_heading_z,
                                          ctr_x, ctr_y, ctr_z, radius));
            if (o_valid && !i_stall) begin
                if (hit_q.size() == 0) begin
                    $error("hit word with nothing expected");
                    errs++;
                end else begin
                    exp_w = hit_q.pop_front();
                    if (o_hit !== exp_w.hit) begin
                        $error("hit: expected %0d, got %0d", exp_w.hit, o_hit);
                        errs++;
                    end
                    if (o_distance !== exp_w.distance) begin
                        $error("distance: expected %h, got %h", exp_w.distance, o_distance);
                        errs++;
                    end
                    if (o_saturated !== exp_w.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_w.saturated, o_saturated);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= hit_q.size();
        end
    end

endmodule

// ----- verif/tb_ray_sphere_intersect.sv -----
// Testbench top for ray_sphere_intersect: clock, reset, ray and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;

    localparam int SETTLE = 140;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0, o_stall;
    logic [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic [31:0] i_heading_x = '0, i_heading_y = '0, i_heading_z = '0;
    logic        o_valid, i_stall = 1'b0;
    logic        o_hit, o_saturated;
    logic [31:0] o_distance;
    int          errors, pending;
    int          idle_pct = 0, stall_pct = 0, quiet_cycles = 0;
    logic [31:0] cx = '0, cy = '0, cz = '0;

    always #2 i_clk = ~i_clk;

    ray_sphere_intersect u_top (.*);

    rsi_checker u_chk (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] r);
        settle();
        cx = x;
        cy = y;
        cz = z;
        reg_write(rsi_pkg::REG_CENTER_X, x);
        reg_write(rsi_pkg::REG_CENTER_Y, y);
        reg_write(rsi_pkg::REG_CENTER_Z, z);
        reg_write(rsi_pkg::REG_RADIUS, r);
    endtask

    task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_origin_z <= oz;
        i_heading_x <= hx;
        i_heading_y <= hy;
        i_heading_z <= hz;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [31:0] spread();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(31, 0);
    endfunction

    task automatic random_ray();
        if ($urandom_range(99) < 20)
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send_ray(cx + spread(), cy + spread(), cz + spread(),
                     spread(), spread(), spread());
    endtask

    task automatic set_mode(int m);
        case (m)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_sphere(32'd0, 32'd0, 32'd0, 32'h0001_0000);
        send_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_ray(-32'sd327680, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
        send_ray(-32'sd327680, 32'd0, 32'd0, -32'sh0001_0000, 32'd0, 32'd0);
        send_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
        send_ray(-32'sd327680, 32'd327680, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
        send_ray(32'h8000_0000, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        send_ray(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        send_ray(32'h7FFF_FFFF, 32'd0, 32'd0, -32'sd1, 32'd0, 32'd0);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'h8000_0000);
        send_ray(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_sphere(spread(), spread(), spread(),
                              {$urandom_range(1) == 1, 31'h0}
                              | ($urandom >> $urandom_range(31, 1)));
                1: set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
                2: set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
                default: set_sphere($urandom, $urandom, $urandom, $urandom);
            endcase
            for (int n = 0; n < 172; n++) begin
                set_mode(n / 43);
                if (ph == 1 && n == 86) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    wait (pending == 0);
                    @(posedge i_clk);
                end
                random_ray();
            end
        end
        i_valid <= 1'b0;
        set_mode(0);
        settle();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- ray_sphere_intersect.f -----
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/rsi_sqrt.sv
rtl/rsi_div.sv
rtl/ray_sphere_intersect.sv
verif/rsi_checker.sv
verif/tb_ray_sphere_intersect.sv
